[hdl/qvr_pkg.sv]
// Shared widths and beat types for the quaternion vector rotation core.
`default_nettype none
package qvr_pkg;

	localparam int DW  = 16;            // field width, signed Q3.12
	localparam int PQW = 2 * DW;        // quaternion pair product
	localparam int NW  = 2 * DW + 1;    // squared norm, unsigned
	localparam int EW  = 2 * DW + 2;    // rotation matrix entry, signed
	localparam int PW  = 3 * DW + 2;    // entry times vector, and row sums
	localparam int RW  = 3 * DW + 2;    // divider remainder
	localparam int QW  = DW + 1;        // rounded quotient magnitude

	typedef struct packed {
		logic signed [DW-1:0] quat_w;
		logic signed [DW-1:0] quat_x;
		logic signed [DW-1:0] quat_y;
		logic signed [DW-1:0] quat_z;
		logic signed [DW-1:0] vec_x;
		logic signed [DW-1:0] vec_y;
		logic signed [DW-1:0] vec_z;
	} qvr_in_t;

	typedef struct packed {
		logic signed [DW-1:0] rot_x;
		logic signed [DW-1:0] rot_y;
		logic signed [DW-1:0] rot_z;
		logic                 zero_quat;
		logic                 saturated;
	} qvr_out_t;

endpackage
`default_nettype wire

[hdl/quaternion_vector_rotation_core.sv]
// Quaternion vector rotation core: pipelined q (0,v) conj(q) / |q|^2.
`default_nettype none
// Rotates one vector per beat by the normalised quaternion that travels with it. The
// normalisation is exact: the core forms N = R(q) v with the unnormalised rotation matrix
// and divides by n = |q|^2, rounding to nearest with ties away from zero, then clamps to
// the 16-bit range (saturated flags a clamp). A zero quaternion gives the zero vector with
// zero_quat set. Throughput is one beat per clock while src_stall is low. The pipeline has 5
// arithmetic stages plus one stage per quotient bit of the pipelined restoring divider (17),
// then the output register.
// A two-entry output buffer (output register plus skid) means src_stall is a register:
// the pipeline freezes only once the skid entry is occupied.
module quaternion_vector_rotation_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_stall,
	input  wire qvr_pkg::qvr_in_t  src_beat,
	output logic                   dst_valid,
	input  wire logic              dst_stall,
	output qvr_pkg::qvr_out_t      dst_beat
);
	import qvr_pkg::*;

	logic en;                       // whole pipeline advances

	// stage 1: quaternion pair products
	logic                  vld_s1;
	logic signed [PQW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [DW-1:0]  v_s1 [3];

	// stage 2: matrix entries (row major) and norm
	logic                  vld_s2;
	logic signed [EW-1:0]  e_s2 [9];
	logic [NW-1:0]         n_s2;
	logic signed [DW-1:0]  v_s2 [3];

	// stage 3: entry times vector component
	logic                  vld_s3;
	logic signed [PW-1:0]  p_s3 [9];
	logic [NW-1:0]         n_s3;

	// stage 4: row sums
	logic                  vld_s4;
	logic signed [PW-1:0]  num_s4 [3];
	logic [NW-1:0]         n_s4;

	// stage 5 and divider: index 0 is stage 5, index k is divider step k
	logic                  div_vld_s  [QW+1];
	logic [RW-1:0]         div_rem_s  [QW+1][3];
	logic [QW-1:0]         div_quo_s  [QW+1][3];
	logic                  div_neg_s  [QW+1][3];
	logic [RW-1:0]         div_d_s    [QW+1];
	logic                  div_zero_s [QW+1];

	logic [PW-1:0]         mag5 [3];
	logic [RW-1:0]         div_nrem [QW][3];
	logic                  div_ge   [QW][3];

	// result and output buffer
	qvr_out_t              res;
	logic                  xfer;
	logic                  out_load;
	qvr_out_t              skid_q;
	logic                  skid_v_q;

	assign en        = !skid_v_q;
	assign src_stall = skid_v_q;

	// ---- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= src_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= src_beat.quat_w * src_beat.quat_w;
			xx_s1 <= src_beat.quat_x * src_beat.quat_x;
			yy_s1 <= src_beat.quat_y * src_beat.quat_y;
			zz_s1 <= src_beat.quat_z * src_beat.quat_z;
			xy_s1 <= src_beat.quat_x * src_beat.quat_y;
			wz_s1 <= src_beat.quat_w * src_beat.quat_z;
			xz_s1 <= src_beat.quat_x * src_beat.quat_z;
			wy_s1 <= src_beat.quat_w * src_beat.quat_y;
			yz_s1 <= src_beat.quat_y * src_beat.quat_z;
			wx_s1 <= src_beat.quat_w * src_beat.quat_x;
			v_s1[0] <= src_beat.vec_x;
			v_s1[1] <= src_beat.vec_y;
			v_s1[2] <= src_beat.vec_z;
		end
	end

	// ---- stage 2: every entry is bounded by n in magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			e_s2[0] <= EW'(ww_s1) + EW'(xx_s1) - EW'(yy_s1) - EW'(zz_s1);
			e_s2[1] <= (EW'(xy_s1) - EW'(wz_s1)) <<< 1;
			e_s2[2] <= (EW'(xz_s1) + EW'(wy_s1)) <<< 1;
			e_s2[3] <= (EW'(xy_s1) + EW'(wz_s1)) <<< 1;
			e_s2[4] <= EW'(ww_s1) - EW'(xx_s1) + EW'(yy_s1) - EW'(zz_s1);
			e_s2[5] <= (EW'(yz_s1) - EW'(wx_s1)) <<< 1;
			e_s2[6] <= (EW'(xz_s1) - EW'(wy_s1)) <<< 1;
			e_s2[7] <= (EW'(yz_s1) + EW'(wx_s1)) <<< 1;
			e_s2[8] <= EW'(ww_s1) - EW'(xx_s1) - EW'(yy_s1) + EW'(zz_s1);
			n_s2    <= NW'(EW'(ww_s1) + EW'(xx_s1) + EW'(yy_s1) + EW'(zz_s1));
			v_s2    <= v_s1;
		end
	end

	// ---- stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				p_s3[i] <= PW'(e_s2[i]) * PW'(v_s2[i % 3]);
			end
			n_s3 <= n_s2;
		end
	end

	// ---- stage 4
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				num_s4[r] <= p_s3[3*r] + p_s3[3*r+1] + p_s3[3*r+2];
			end
			n_s4 <= n_s3;
		end
	end

	// ---- stage 5: dividend 2|N| + n over divisor 2n gives the rounded quotient
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mag5[r] = num_s4[r][PW-1] ? PW'(-num_s4[r]) : PW'(num_s4[r]);
		end
	end

	// ---- divider steps, one quotient bit each, MSB first
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < 3; l++) begin
				div_ge[k][l]   = div_rem_s[k][l] >= (div_d_s[k] << (QW - 1 - k));
				div_nrem[k][l] = div_ge[k][l] ?
					div_rem_s[k][l] - (div_d_s[k] << (QW - 1 - k)) : div_rem_s[k][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				div_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			div_vld_s[0] <= vld_s4;
			for (int k = 0; k < QW; k++) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				div_rem_s[0][r] <= (RW'(mag5[r]) << 1) + RW'(n_s4);
				div_quo_s[0][r] <= '0;
				div_neg_s[0][r] <= num_s4[r][PW-1];
			end
			div_d_s[0]    <= RW'(n_s4) << 1;
			div_zero_s[0] <= (n_s4 == '0);
			for (int k = 0; k < QW; k++) begin
				for (int l = 0; l < 3; l++) begin
					div_rem_s[k+1][l] <= div_nrem[k][l];
					div_quo_s[k+1][l] <= {div_quo_s[k][l][QW-2:0], div_ge[k][l]};
					div_neg_s[k+1][l] <= div_neg_s[k][l];
				end
				div_d_s[k+1]    <= div_d_s[k];
				div_zero_s[k+1] <= div_zero_s[k];
			end
		end
	end

	// ---- clamp and sign restore
	always_comb begin
		logic [QW-1:0]       lim;
		logic [QW-1:0]       m;
		logic signed [DW-1:0] comp [3];
		logic                sat;
		sat = 1'b0;
		for (int l = 0; l < 3; l++) begin
			lim = div_neg_s[QW][l] ? QW'(1) << (DW - 1) : (QW'(1) << (DW - 1)) - QW'(1);
			m   = div_quo_s[QW][l];
			if (m > lim) begin
				m   = lim;
				sat = 1'b1;
			end
			comp[l] = div_neg_s[QW][l] ? DW'(-m) : DW'(m);
		end
		if (div_zero_s[QW]) begin
			res = '{rot_x: '0, rot_y: '0, rot_z: '0, zero_quat: 1'b1, saturated: 1'b0};
		end else begin
			res = '{rot_x: comp[0], rot_y: comp[1], rot_z: comp[2],
				zero_quat: 1'b0, saturated: sat};
		end
	end

	// ---- output register with skid entry
	assign xfer     = div_vld_s[QW] && en;
	assign out_load = !dst_valid || !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_load) begin
			dst_valid <= skid_v_q || xfer;
			skid_v_q  <= 1'b0;
		end else if (xfer) begin
			skid_v_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dst_beat <= skid_v_q ? skid_q : res;
		end else if (xfer) begin
			skid_q <= res;
		end
	end

	// ---- checks
	a_skid_only_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> dst_valid) else $error("skid entry filled without a held output beat");

	a_zero_quat_result: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_beat.zero_quat |-> !dst_beat.saturated && dst_beat.rot_x == '0 &&
		dst_beat.rot_y == '0 && dst_beat.rot_z == '0)
		else $error("zero quaternion beat carries a non-zero result");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !dst_stall |=> dst_valid && !skid_v_q)
		else $error("skid entry not moved to the output register");

endmodule
`default_nettype wire
